[hdl/ltc_pkg.sv]
package ltc_pkg;

  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int LEN_W   = 4;
  localparam int STAMP_W = 32;
  localparam int VAL_BYTES = 8;

  localparam logic [LEN_W-1:0]   MAX_LEN   = 4'd8;
  localparam logic [STAMP_W-1:0] CLOCK_MAX = 32'hFFFF_FFFF;
  localparam logic [STAMP_W-1:0] CLOCK_INIT = 32'd1;

  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_we;
    logic rd_en;
    logic dat_vld;
    logic commit;
    logic out_valid;
  } seq_ctl_t;

endpackage

[hdl/ltc_if.sv]
interface ltc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ltc_pkg::KEY_W-1:0]     key;
  logic [ltc_pkg::VAL_W-1:0]     value;
  logic [ltc_pkg::LEN_W-1:0]     value_length;

  modport source (output valid, opcode, key, value, value_length, input ready);
  modport sink   (input valid, opcode, key, value, value_length, output ready);
endinterface

interface ltc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [ltc_pkg::VAL_W-1:0]     value_res;
  logic [ltc_pkg::LEN_W-1:0]     value_length_res;

  modport source (output valid, hit, value_res, value_length_res, input ready);
  modport sink   (input valid, hit, value_res, value_length_res, output ready);
endinterface

[hdl/ltc_ram.sv]
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ltc_seq.sv]
module ltc_seq #(
  parameter int SLOTS = 16,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  input  logic               is_insert,
  output ltc_pkg::seq_ctl_t  ctl,
  output logic [AW-1:0]      addr,
  output logic [AW-1:0]      dat_idx
);

  ltc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            dat_vld_r;
  logic [AW-1:0]   dat_idx_r;

  logic clr_last;
  logic scan_last;

  assign clr_last  = (cnt_r == CW'(SLOTS - 1));
  assign scan_last = (cnt_r == CW'(SLOTS));

  // next state and slot counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ltc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ltc_pkg::ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ltc_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) begin
          state_nxt = ltc_pkg::ST_SCAN;
        end
      end
      ltc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = is_insert ? ltc_pkg::ST_COMMIT : ltc_pkg::ST_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ltc_pkg::ST_COMMIT: begin
        state_nxt = ltc_pkg::ST_OUT;
      end
      ltc_pkg::ST_OUT: begin
        if (out_fire) begin
          state_nxt = ltc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ltc_pkg::ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control outputs
  always_comb begin
    ctl           = '0;
    ctl.dat_vld   = dat_vld_r;
    case (state_r)
      ltc_pkg::ST_CLEAR:  ctl.clr_we    = 1'b1;
      ltc_pkg::ST_IDLE:   ctl.in_ready  = 1'b1;
      ltc_pkg::ST_SCAN:   ctl.rd_en     = !scan_last;
      ltc_pkg::ST_COMMIT: ctl.commit    = 1'b1;
      ltc_pkg::ST_OUT:    ctl.out_valid = 1'b1;
      default:            ctl           = '0;
    endcase
  end

  assign addr    = cnt_r[AW-1:0];
  assign dat_idx = dat_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ltc_pkg::ST_CLEAR;
      cnt_r     <= '0;
      dat_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      dat_vld_r <= ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    dat_idx_r <= cnt_r[AW-1:0];
  end

endmodule

[hdl/lru_timestamp_cache_top.sv]
// Find: the input beat is taken in ST_IDLE, then ST_SCAN, then the result in ST_OUT;
// insert: ST_SCAN, ST_COMMIT, ST_OUT. One request at a time: the slot scan reads one
// entry per cycle from the single read port of the entry RAM, and the result beat
// is held in ST_OUT until out_bus.ready.
// Reset (rst_n low, synchronous) sets the use clock to one and then runs a clearing
// pass over all SLOTS slots that zeroes every stamp; in_ready stays low until it ends.
module lru_timestamp_cache_top #(
  parameter int SLOTS    = 16,
  parameter int KEY_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ltc_in_if.sink    in_bus,
  ltc_out_if.source out_bus
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // entry layout: {stamp, length, value, key}
  localparam int VAL_LSB   = KEY_BITS;
  localparam int LEN_LSB   = VAL_LSB + ltc_pkg::VAL_W;
  localparam int STAMP_LSB = LEN_LSB + ltc_pkg::LEN_W;
  localparam int EW        = STAMP_LSB + ltc_pkg::STAMP_W;

  ltc_pkg::seq_ctl_t ctl;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     dat_idx;
  logic              in_fire;
  logic              out_fire;

  // request held for the length of the scan
  logic                          op_r;
  logic [KEY_BITS-1:0]           key_r;
  logic [ltc_pkg::VAL_W-1:0]     val_r;
  logic [ltc_pkg::LEN_W-1:0]     len_r;

  // scan state and result
  logic [ltc_pkg::STAMP_W-1:0]   clock_r;
  logic [ltc_pkg::STAMP_W-1:0]   clock_nxt;
  logic [ltc_pkg::STAMP_W-1:0]   best_r;
  logic [AW-1:0]                 victim_r;
  logic                          hit_r;
  logic [ltc_pkg::VAL_W-1:0]     res_val_r;
  logic [ltc_pkg::LEN_W-1:0]     res_len_r;

  logic [ltc_pkg::LEN_W-1:0]     len_sat;
  logic [ltc_pkg::VAL_W-1:0]     val_masked;

  logic [EW-1:0]                 rdata;
  logic [KEY_BITS-1:0]           e_key;
  logic [ltc_pkg::VAL_W-1:0]     e_val;
  logic [ltc_pkg::LEN_W-1:0]     e_len;
  logic [ltc_pkg::STAMP_W-1:0]   e_stamp;

  logic                          find_match;
  logic                          take_min;
  logic                          clock_adv;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [EW-1:0]                 ram_wdata;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;

  ltc_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .is_insert (op_r == ltc_pkg::OP_INSERT),
    .ctl       (ctl),
    .addr      (addr),
    .dat_idx   (dat_idx)
  );

  ltc_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  // saturate the length and drop the value bytes above it
  always_comb begin
    len_sat = (in_bus.value_length > ltc_pkg::MAX_LEN) ? ltc_pkg::MAX_LEN
                                                       : in_bus.value_length;
    for (int b = 0; b < ltc_pkg::VAL_BYTES; b++) begin
      val_masked[b*8 +: 8] = (ltc_pkg::LEN_W'(b) < len_sat) ? in_bus.value[b*8 +: 8]
                                                             : 8'h00;
    end
  end

  // unpack the entry coming back from the RAM
  assign e_key   = rdata[KEY_BITS-1:0];
  assign e_val   = rdata[VAL_LSB +: ltc_pkg::VAL_W];
  assign e_len   = rdata[LEN_LSB +: ltc_pkg::LEN_W];
  assign e_stamp = rdata[STAMP_LSB +: ltc_pkg::STAMP_W];

  // shared compare step: key match on a find, smallest stamp on an insert
  assign find_match = ctl.dat_vld && (op_r == ltc_pkg::OP_FIND) &&
                      (e_stamp != '0) && (e_key == key_r);
  assign take_min   = (dat_idx == '0) || (e_stamp < best_r);

  // each stamp handed out advances the clock, which stops at its maximum
  assign clock_adv = find_match || ctl.commit;
  assign clock_nxt = (clock_r == ltc_pkg::CLOCK_MAX) ? clock_r
                                                      : clock_r + ltc_pkg::STAMP_W'(1);

  // write port: clearing pass, stamp refresh on a find hit, or the insert commit
  assign ram_we = ctl.clr_we || find_match || ctl.commit;

  always_comb begin
    if (ctl.clr_we) begin
      ram_waddr = addr;
      ram_wdata = '0;
    end else if (ctl.commit) begin
      ram_waddr = victim_r;
      ram_wdata = {clock_r, len_r, val_r, key_r};
    end else begin
      ram_waddr = dat_idx;
      ram_wdata = {clock_r, e_len, e_val, e_key};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r   <= ltc_pkg::CLOCK_INIT;
      op_r      <= ltc_pkg::OP_FIND;
      hit_r     <= 1'b0;
      res_val_r <= '0;
      res_len_r <= '0;
    end else begin
      if (clock_adv) begin
        clock_r <= clock_nxt;
      end
      if (in_fire) begin
        op_r      <= in_bus.opcode;
        hit_r     <= 1'b0;
        res_val_r <= '0;
        res_len_r <= '0;
      end else if (find_match) begin
        // later matches overwrite earlier ones
        hit_r     <= 1'b1;
        res_val_r <= e_val;
        res_len_r <= e_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_bus.key[KEY_BITS-1:0];
      val_r <= val_masked;
      len_r <= len_sat;
    end
    // track the least recently used slot, lowest index on a tie
    if (ctl.dat_vld && (op_r == ltc_pkg::OP_INSERT) && take_min) begin
      best_r   <= e_stamp;
      victim_r <= dat_idx;
    end
  end

  assign in_bus.ready              = ctl.in_ready;
  assign out_bus.valid             = ctl.out_valid;
  assign out_bus.hit               = hit_r;
  assign out_bus.value_res         = res_val_r;
  assign out_bus.value_length_res  = res_len_r;

`ifndef SYNTH
  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (clock_r >= $past(clock_r)))
    else $error("use clock went backward");

  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ((clock_r - $past(clock_r)) <= ltc_pkg::STAMP_W'(1)))
    else $error("use clock advanced by more than one in a cycle");

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !in_bus.ready)
    else $error("input taken while a result beat is pending");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.in_ready |-> !ram_we)
    else $error("entry RAM written while idle");

  a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (op_r == ltc_pkg::OP_INSERT)) |-> !out_bus.hit)
    else $error("insert reported a hit");
`endif

endmodule
